// File: src/dtc_pkg.sv
// Shared types, constants and widths for the degenerate triangle cull block.
// Used by every module under src except dtc_ram; depends on nothing.
`default_nettype none

package dtc_pkg;

  // Vertex store geometry
  localparam int VERTEX_DEPTH = 1024;
  localparam int COORD_BITS   = 16;
  localparam int VADDR_W      = $clog2(VERTEX_DEPTH);
  localparam int VERTEX_W     = 3 * COORD_BITS;

  // Fixed field widths
  localparam int IDX_W     = 10;
  localparam int POS_W     = 16;
  localparam int VERDICT_W = 2;
  localparam int VIU_W     = 11;
  localparam int THR_W     = 63;
  localparam int CFG_IDX_W = 1;

  // Input tdata layout, lowest bit first
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_X_LSB    = IN_SLOT_LSB + IDX_W;
  localparam int IN_Y_LSB    = IN_X_LSB + POS_W;
  localparam int IN_Z_LSB    = IN_Y_LSB + POS_W;
  localparam int IN_C0_LSB   = IN_Z_LSB + POS_W;
  localparam int IN_C1_LSB   = IN_C0_LSB + IDX_W;
  localparam int IN_C2_LSB   = IN_C1_LSB + IDX_W;
  localparam int IN_FIELDS_W = IN_C2_LSB + IDX_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata layout: verdict, then the three corner echoes
  localparam int OUT_FIELDS_W = VERDICT_W + 3 * IDX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = 2 * COORD_BITS + 2;
  localparam int HALF_W  = MAG_W / 2;
  localparam int PART_W  = 2 * HALF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;

  typedef enum logic {
    CMD_VERTEX   = 1'b0,
    CMD_TRIANGLE = 1'b1
  } command_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_KEPT   = 2'd0,
    VERDICT_REPEAT = 2'd1,
    VERDICT_SMALL  = 2'd2,
    VERDICT_INDEX  = 2'd3
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTICES_IN_USE = 1'b0,
    REG_AREA_THRESHOLD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C
  } corner_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_DIFF,
    ST_PROD,
    ST_CROSS,
    ST_MAG,
    ST_SQ,
    ST_SQSUM,
    ST_TOT,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic        ram_we;
    logic        load_tri;
    corner_sel_t rd_sel;
    logic        cap_a;
    logic        cap_b;
    logic        sum_en;
    logic        out_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic early;   // index error or repeated corner, no area needed
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/dtc_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module dtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/dtc_ctrl.sv
// Sequencer for the cull block: input/output handshakes and datapath steps.
// Depends on dtc_pkg.
`default_nettype none

module dtc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_command,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire dtc_pkg::dp_stat_t stat,
  output dtc_pkg::ctl_cmd_t     cmd
);

  dtc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_acc;
  logic            out_free;

  assign in_tready = (state_r == dtc_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtc_pkg::ST_IDLE: begin
        if (in_acc && (in_command == dtc_pkg::CMD_TRIANGLE)) begin
          state_nxt = dtc_pkg::ST_RD_A;
        end
      end
      dtc_pkg::ST_RD_A:  state_nxt = stat.early ? dtc_pkg::ST_DONE : dtc_pkg::ST_RD_B;
      dtc_pkg::ST_RD_B:  state_nxt = dtc_pkg::ST_RD_C;
      dtc_pkg::ST_RD_C:  state_nxt = dtc_pkg::ST_DIFF;
      dtc_pkg::ST_DIFF:  state_nxt = dtc_pkg::ST_PROD;
      dtc_pkg::ST_PROD:  state_nxt = dtc_pkg::ST_CROSS;
      dtc_pkg::ST_CROSS: state_nxt = dtc_pkg::ST_MAG;
      dtc_pkg::ST_MAG:   state_nxt = dtc_pkg::ST_SQ;
      dtc_pkg::ST_SQ:    state_nxt = dtc_pkg::ST_SQSUM;
      dtc_pkg::ST_SQSUM: state_nxt = dtc_pkg::ST_TOT;
      dtc_pkg::ST_TOT:   state_nxt = dtc_pkg::ST_DONE;
      dtc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = dtc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtc_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = dtc_pkg::SEL_C;
    unique case (state_r)
      dtc_pkg::ST_IDLE: begin
        cmd.ram_we   = in_acc & (in_command == dtc_pkg::CMD_VERTEX);
        cmd.load_tri = in_acc & (in_command == dtc_pkg::CMD_TRIANGLE);
      end
      dtc_pkg::ST_RD_A: begin
        cmd.rd_sel = dtc_pkg::SEL_A;
      end
      dtc_pkg::ST_RD_B: begin
        cmd.rd_sel = dtc_pkg::SEL_B;
        cmd.cap_a  = 1'b1;
      end
      dtc_pkg::ST_RD_C: begin
        cmd.rd_sel = dtc_pkg::SEL_C;
        cmd.cap_b  = 1'b1;
      end
      dtc_pkg::ST_TOT: begin
        cmd.sum_en = 1'b1;
      end
      dtc_pkg::ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.rd_sel = dtc_pkg::SEL_C;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_tready);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/dtc_datapath.sv
// Datapath: config registers, vertex RAM, corner checks, cross product,
// exact squared length and the output register. Depends on dtc_pkg, dtc_ram.
`default_nettype none

module dtc_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [dtc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtc_pkg::THR_W-1:0]         cfg_data,
  input  wire dtc_pkg::ctl_cmd_t                 cmd,
  output dtc_pkg::dp_stat_t                      stat,
  output logic      [dtc_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic [dtc_pkg::VIU_W-1:0] viu_r, viu_nxt;
  logic [dtc_pkg::THR_W-1:0] thr_r, thr_nxt;

  logic [dtc_pkg::IDX_W-1:0]    slot;
  logic [dtc_pkg::IDX_W-1:0]    idx_r [3];
  logic                         ram_we;
  logic [dtc_pkg::VADDR_W-1:0]  ram_addr;
  logic [dtc_pkg::VERTEX_W-1:0] ram_wdata;
  logic [dtc_pkg::VERTEX_W-1:0] ram_rdata;

  logic signed [dtc_pkg::COORD_BITS-1:0] rd_c [3];
  logic signed [dtc_pkg::COORD_BITS-1:0] pa_r [3];
  logic signed [dtc_pkg::COORD_BITS-1:0] pb_r [3];
  logic signed [dtc_pkg::DIFF_W-1:0]     ab_r [3];
  logic signed [dtc_pkg::DIFF_W-1:0]     ac_r [3];
  logic signed [dtc_pkg::PROD_W-1:0]     p_r  [6];
  logic signed [dtc_pkg::CROSS_W-1:0]    n_r  [3];
  logic        [dtc_pkg::CROSS_W-1:0]    abs_c [3];
  logic        [dtc_pkg::MAG_W-1:0]      m_r  [3];
  logic        [dtc_pkg::HALF_W-1:0]     hi_c [3];
  logic        [dtc_pkg::HALF_W-1:0]     lo_c [3];
  logic        [dtc_pkg::PART_W-1:0]     hh_r [3];
  logic        [dtc_pkg::PART_W-1:0]     hl_r [3];
  logic        [dtc_pkg::PART_W-1:0]     ll_r [3];
  logic        [dtc_pkg::SQ_W-1:0]       sq_r [3];
  logic        [dtc_pkg::SUM_W-1:0]      sum_r;

  logic                               oob;
  logic                               rpt;
  logic                               small_area;
  dtc_pkg::verdict_t                  verdict;
  logic [dtc_pkg::OUT_DATA_W-1:0]     out_r;

  // ---------------- configuration registers ----------------
  always_comb begin
    viu_nxt = viu_r;
    thr_nxt = thr_r;
    if (cfg_we) begin
      unique case (dtc_pkg::cfg_reg_t'(cfg_index))
        dtc_pkg::REG_VERTICES_IN_USE: viu_nxt = cfg_data[dtc_pkg::VIU_W-1:0];
        dtc_pkg::REG_AREA_THRESHOLD:  thr_nxt = cfg_data;
        default: begin
          viu_nxt = viu_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viu_r <= '0;
      thr_r <= '0;
    end else begin
      viu_r <= viu_nxt;
      thr_r <= thr_nxt;
    end
  end

  // ---------------- vertex store ----------------
  assign slot   = in_tdata[dtc_pkg::IN_SLOT_LSB +: dtc_pkg::IDX_W];
  // slots past the store are dropped
  assign ram_we = cmd.ram_we & (32'(slot) < dtc_pkg::VERTEX_DEPTH);
  assign ram_wdata = {
    dtc_pkg::COORD_BITS'(in_tdata[dtc_pkg::IN_Z_LSB +: dtc_pkg::POS_W]),
    dtc_pkg::COORD_BITS'(in_tdata[dtc_pkg::IN_Y_LSB +: dtc_pkg::POS_W]),
    dtc_pkg::COORD_BITS'(in_tdata[dtc_pkg::IN_X_LSB +: dtc_pkg::POS_W])
  };

  always_comb begin
    if (cmd.ram_we) begin
      ram_addr = dtc_pkg::VADDR_W'(slot);
    end else begin
      unique case (cmd.rd_sel)
        dtc_pkg::SEL_A: ram_addr = dtc_pkg::VADDR_W'(idx_r[0]);
        dtc_pkg::SEL_B: ram_addr = dtc_pkg::VADDR_W'(idx_r[1]);
        dtc_pkg::SEL_C: ram_addr = dtc_pkg::VADDR_W'(idx_r[2]);
        default:        ram_addr = dtc_pkg::VADDR_W'(idx_r[2]);
      endcase
    end
  end

  dtc_ram #(
    .WIDTH (dtc_pkg::VERTEX_W),
    .DEPTH (dtc_pkg::VERTEX_DEPTH)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------- corner checks ----------------
  always_comb begin
    oob = 1'b0;
    for (int k = 0; k < 3; k++) begin
      oob = oob | (32'(idx_r[k]) >= dtc_pkg::VERTEX_DEPTH)
                | (dtc_pkg::VIU_W'(idx_r[k]) >= viu_r);
    end
  end

  assign rpt = (idx_r[0] == idx_r[1]) | (idx_r[1] == idx_r[2]) | (idx_r[2] == idx_r[0]);
  assign stat.early = oob | rpt;

  // ---------------- arithmetic ----------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rd_c[c]  = $signed(ram_rdata[c*dtc_pkg::COORD_BITS +: dtc_pkg::COORD_BITS]);
      abs_c[c] = n_r[c][dtc_pkg::CROSS_W-1] ? -n_r[c] : n_r[c];
      hi_c[c]  = m_r[c][dtc_pkg::MAG_W-1:dtc_pkg::HALF_W];
      lo_c[c]  = m_r[c][dtc_pkg::HALF_W-1:0];
    end
  end

  // Free-running stages; the sequencer only picks when to capture.
  always_ff @(posedge clk) begin
    if (cmd.load_tri) begin
      idx_r[0] <= in_tdata[dtc_pkg::IN_C0_LSB +: dtc_pkg::IDX_W];
      idx_r[1] <= in_tdata[dtc_pkg::IN_C1_LSB +: dtc_pkg::IDX_W];
      idx_r[2] <= in_tdata[dtc_pkg::IN_C2_LSB +: dtc_pkg::IDX_W];
    end
    for (int c = 0; c < 3; c++) begin
      if (cmd.cap_a) begin
        pa_r[c] <= rd_c[c];
      end
      if (cmd.cap_b) begin
        pb_r[c] <= rd_c[c];
      end
      // edges B-A and C-A; C arrives straight from the RAM
      ab_r[c] <= dtc_pkg::DIFF_W'(pb_r[c]) - dtc_pkg::DIFF_W'(pa_r[c]);
      ac_r[c] <= dtc_pkg::DIFF_W'(rd_c[c]) - dtc_pkg::DIFF_W'(pa_r[c]);
      n_r[c]  <= dtc_pkg::CROSS_W'(p_r[2*c]) - dtc_pkg::CROSS_W'(p_r[2*c+1]);
      m_r[c]  <= abs_c[c][dtc_pkg::MAG_W-1:0];
      // m^2 from half-width products
      hh_r[c] <= hi_c[c] * hi_c[c];
      hl_r[c] <= hi_c[c] * lo_c[c];
      ll_r[c] <= lo_c[c] * lo_c[c];
      sq_r[c] <= (dtc_pkg::SQ_W'(hh_r[c]) << dtc_pkg::PART_W)
               + (dtc_pkg::SQ_W'(hl_r[c]) << (dtc_pkg::HALF_W + 1))
               + dtc_pkg::SQ_W'(ll_r[c]);
    end
    p_r[0] <= dtc_pkg::PROD_W'(ab_r[1]) * dtc_pkg::PROD_W'(ac_r[2]);
    p_r[1] <= dtc_pkg::PROD_W'(ab_r[2]) * dtc_pkg::PROD_W'(ac_r[1]);
    p_r[2] <= dtc_pkg::PROD_W'(ab_r[2]) * dtc_pkg::PROD_W'(ac_r[0]);
    p_r[3] <= dtc_pkg::PROD_W'(ab_r[0]) * dtc_pkg::PROD_W'(ac_r[2]);
    p_r[4] <= dtc_pkg::PROD_W'(ab_r[0]) * dtc_pkg::PROD_W'(ac_r[1]);
    p_r[5] <= dtc_pkg::PROD_W'(ab_r[1]) * dtc_pkg::PROD_W'(ac_r[0]);
    if (cmd.sum_en) begin
      sum_r <= dtc_pkg::SUM_W'(sq_r[0]) + dtc_pkg::SUM_W'(sq_r[1])
             + dtc_pkg::SUM_W'(sq_r[2]);
    end
    if (cmd.out_load) begin
      out_r <= dtc_pkg::OUT_DATA_W'({idx_r[2], idx_r[1], idx_r[0], verdict});
    end
  end

  // threshold fits in 63 bits, so anything at or above 2^63 compares greater
  assign small_area = (dtc_pkg::CMP_W'(sum_r) <= dtc_pkg::CMP_W'(thr_r));

  always_comb begin
    if (oob) begin
      verdict = dtc_pkg::VERDICT_INDEX;
    end else if (rpt) begin
      verdict = dtc_pkg::VERDICT_REPEAT;
    end else if (small_area) begin
      verdict = dtc_pkg::VERDICT_SMALL;
    end else begin
      verdict = dtc_pkg::VERDICT_KEPT;
    end
  end

  assign out_tdata = out_r;

endmodule

`default_nettype wire

// File: src/degenerate_triangle_cull_top.sv
// Top level of the degenerate triangle cull block: sequencer plus datapath.
// Depends on dtc_pkg, dtc_ctrl, dtc_datapath (and dtc_ram below it).
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------------
//   in_      | in  | in_tvalid / in_tready  | in_tuser command, in_tdata fields
//   out_     | out | out_tvalid / out_tready| out_tdata verdict + corner echoes
//   cfg_     | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// Vertex write: no result. Triangle: three serial reads of the single-port
// vertex RAM, seven register stages, result step, idle; an index error or
// repeated corner skips the area math.
// Reset is synchronous, active low; it clears the sequencer, output valid and
// both config registers. The vertex RAM is not cleared. Input stalls while a
// triangle runs, and at the result step while the previous result is unclaimed.
`default_nettype none

module degenerate_triangle_cull_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata, low bit first: vertex_slot[10], pos_x[16], pos_y[16], pos_z[16],
  //   corner_first[10], corner_second[10], corner_third[10]
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [dtc_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: command[1] (0 vertex write, 1 triangle test)
  input  wire logic                              in_tuser,
  // out_tdata, low bit first: verdict[2], kept_first[10], kept_second[10],
  //   kept_third[10]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [dtc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // config: index 0 vertices_in_use, index 1 area_threshold
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtc_pkg::THR_W-1:0]         cfg_data
);

  dtc_pkg::ctl_cmd_t cmd;
  dtc_pkg::dp_stat_t stat;

  // config writes are always taken and act at once; send them with no request in flight
  assign cfg_ready = 1'b1;

  dtc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dtc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// File: src/dtc_checker.sv
// Port-level checks for the cull block, bound onto the top level.
// Depends on dtc_pkg and degenerate_triangle_cull_top.
`default_nettype none

module dtc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [dtc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // reset leaves the block ready and with nothing to deliver
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

  // a triangle keeps the input side busy after it is taken
  a_tri_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == dtc_pkg::CMD_TRIANGLE)
      |=> !in_tready ##1 !in_tready)
    else $error("request taken during triangle test");

  // a vertex write never produces a result
  a_vertex_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == dtc_pkg::CMD_VERTEX) && !out_tvalid
      |=> !out_tvalid)
    else $error("result after vertex write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind degenerate_triangle_cull_top dtc_checker u_dtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/degenerate_triangle_cull_top_test.sv
// Self-checking bench for degenerate_triangle_cull_top: vertex writes and triangle tests in,
// one status per triangle out, checked against an in-bench verdict predictor.
// Depends on dtc_pkg and the degenerate_triangle_cull_top RTL only.

module degenerate_triangle_cull_top_test;
  import dtc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 300;
  localparam int FILL_COUNT = 64;      // store entries written up front

  // one request as the sender sees it
  typedef struct packed {
    command_t                cmd;
    logic [IDX_W-1:0]        slot;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [IDX_W-1:0]        c0;
    logic [IDX_W-1:0]        c1;
    logic [IDX_W-1:0]        c2;
  } mesh_req_t;

  // one triangle status as the block should report it
  typedef struct {
    verdict_t         verdict;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] third;
  } cull_status_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [THR_W-1:0]      cfg_data;

  degenerate_triangle_cull_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  mesh_req_t    mesh_requests[$];    // filled by the stimulus block, drained by the driver
  cull_status_t awaited_status[$];   // predicted statuses, oldest first
  mesh_req_t    cur_req;

  // predictor copy of the block: config registers and vertex store
  logic [VIU_W-1:0]        live_vertex_count;
  logic [THR_W-1:0]        live_area_limit;
  logic signed [POS_W-1:0] vert_x[VERTEX_DEPTH];
  logic signed [POS_W-1:0] vert_y[VERTEX_DEPTH];
  logic signed [POS_W-1:0] vert_z[VERTEX_DEPTH];

  // stimulus-side view of the store, used to build degenerate triangles
  logic signed [POS_W-1:0] plan_x[VERTEX_DEPTH];
  logic signed [POS_W-1:0] plan_y[VERTEX_DEPTH];
  logic signed [POS_W-1:0] plan_z[VERTEX_DEPTH];
  int                      cur_viu;

  logic in_fire;          // request taken at the last rising edge
  int   cfg_count;        // config writes taken so far
  int   cycle_count;
  int   mismatch_count;
  int   vertex_writes;
  int   triangle_tests;
  int   verdict_tally[4];

  // sender pacing
  int burst_left;
  int gap_left;

  // receiver pacing; the stimulus block asks for a long hold by bumping hold_requests
  int hold_requests;
  int hold_served;
  int hold_left;
  int rx_cycle;
  int rx_mode;

  // ---------------------------------------------------------------------------
  // Predictor: verdict for one triangle against the current store and registers
  // ---------------------------------------------------------------------------
  function automatic verdict_t predict_verdict(input logic [IDX_W-1:0] a, b, c);
    logic [VIU_W-1:0] span;
    longint           px[3], py[3], pz[3];
    longint           ux, uy, uz, wx, wy, wz;
    longint           nrm[3];
    logic [127:0]     mag;
    logic [127:0]     area2;
    logic [IDX_W-1:0] idx[3];
    int               k;
    span = (live_vertex_count < VIU_W'(VERTEX_DEPTH)) ? live_vertex_count
                                                      : VIU_W'(VERTEX_DEPTH);
    // index error outranks a repeated corner, which outranks the area test
    if (a >= span || b >= span || c >= span)
      return VERDICT_INDEX;
    if (a == b || b == c || c == a)
      return VERDICT_REPEAT;
    idx[0] = a;
    idx[1] = b;
    idx[2] = c;
    for (k = 0; k < 3; k++) begin
      px[k] = vert_x[idx[k]];
      py[k] = vert_y[idx[k]];
      pz[k] = vert_z[idx[k]];
    end
    ux = px[1] - px[0];
    uy = py[1] - py[0];
    uz = pz[1] - pz[0];
    wx = px[2] - px[0];
    wy = py[2] - py[0];
    wz = pz[2] - pz[0];
    nrm[0] = uy * wz - uz * wy;
    nrm[1] = uz * wx - ux * wz;
    nrm[2] = ux * wy - uy * wx;
    // exact squared length; anything past 63 bits is above any threshold
    area2 = '0;
    for (k = 0; k < 3; k++) begin
      mag = (nrm[k] < 0) ? -nrm[k] : nrm[k];
      area2 = area2 + mag * mag;
    end
    if (area2 <= {65'd0, live_area_limit})
      return VERDICT_SMALL;
    return VERDICT_KEPT;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_request(input mesh_req_t r);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_SLOT_LSB +: IDX_W] = r.slot;
    d[IN_X_LSB +: POS_W]    = r.x;
    d[IN_Y_LSB +: POS_W]    = r.y;
    d[IN_Z_LSB +: POS_W]    = r.z;
    d[IN_C0_LSB +: IDX_W]   = r.c0;
    d[IN_C1_LSB +: IDX_W]   = r.c1;
    d[IN_C2_LSB +: IDX_W]   = r.c2;
    return d;
  endfunction

  // random coordinate spread over +-2^(bits-1)
  function automatic logic signed [POS_W-1:0] rand_coord(input int bits);
    logic signed [POS_W-1:0] raw;
    raw = POS_W'($urandom);
    return raw >>> (POS_W - bits);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers requests from mesh_requests in bursts, changes at falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    mesh_req_t nxt;
    logic      offer;
    offer = in_tvalid && !in_fire;   // still waiting for the block to take it
    nxt   = cur_req;
    if (!offer && rst_n) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (mesh_requests.size() != 0) begin
        nxt   = mesh_requests.pop_front();
        offer = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          // a quarter of bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
    cur_req   = nxt;
    in_tvalid <= offer;
    in_tuser  <= nxt.cmd;
    in_tdata  <= pack_request(nxt);
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern plus long holds on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    rx_cycle = rx_cycle + 1;
    if (rx_cycle % 50 == 0)
      rx_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rdy = 1'b0;
    end else begin
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_cycle % 7) < 3;
      endcase
    end
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor and predictor: sample at rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cull_status_t     want;
    logic [IDX_W-1:0] slot, ca, cb, cc;
    verdict_t         got_verdict;
    logic [IDX_W-1:0] got_first, got_second, got_third;
    cycle_count <= cycle_count + 1;
    in_fire     <= in_tvalid && in_tready;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d statuses outstanding", $time,
               cycle_count, awaited_status.size());
      $display("degenerate_triangle_cull_top regression: fail");
      $finish;
    end else if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_VERTICES_IN_USE: live_vertex_count = cfg_data[VIU_W-1:0];
          REG_AREA_THRESHOLD:  live_area_limit   = cfg_data;
          default: ;
        endcase
        cfg_count <= cfg_count + 1;
      end

      // compare before pushing: a request taken now cannot finish at this edge
      if (out_tvalid && out_tready) begin
        got_verdict = verdict_t'(out_tdata[0 +: VERDICT_W]);
        got_first   = out_tdata[VERDICT_W +: IDX_W];
        got_second  = out_tdata[VERDICT_W + IDX_W +: IDX_W];
        got_third   = out_tdata[VERDICT_W + 2 * IDX_W +: IDX_W];
        if (awaited_status.size() == 0) begin
          $display("%0t: status with none awaited, expected nothing, actual %h", $time,
                   out_tdata);
          mismatch_count++;
        end else begin
          want = awaited_status.pop_front();
          verdict_tally[want.verdict]++;
          if (got_verdict !== want.verdict) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d", $time,
                     want.verdict, got_verdict);
            mismatch_count++;
          end
          if (got_first !== want.first) begin
            $display("%0t: kept_first mismatch, expected %0d, actual %0d", $time,
                     want.first, got_first);
            mismatch_count++;
          end
          if (got_second !== want.second) begin
            $display("%0t: kept_second mismatch, expected %0d, actual %0d", $time,
                     want.second, got_second);
            mismatch_count++;
          end
          if (got_third !== want.third) begin
            $display("%0t: kept_third mismatch, expected %0d, actual %0d", $time,
                     want.third, got_third);
            mismatch_count++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        slot = in_tdata[IN_SLOT_LSB +: IDX_W];
        ca   = in_tdata[IN_C0_LSB +: IDX_W];
        cb   = in_tdata[IN_C1_LSB +: IDX_W];
        cc   = in_tdata[IN_C2_LSB +: IDX_W];
        if (command_t'(in_tuser) == CMD_VERTEX) begin
          vert_x[slot] = in_tdata[IN_X_LSB +: POS_W];
          vert_y[slot] = in_tdata[IN_Y_LSB +: POS_W];
          vert_z[slot] = in_tdata[IN_Z_LSB +: POS_W];
          vertex_writes++;
        end else begin
          want.verdict = predict_verdict(ca, cb, cc);
          want.first   = ca;
          want.second  = cb;
          want.third   = cc;
          awaited_status = {awaited_status, want};
          triangle_tests++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_vertex(input int slot, input int x, y, z);
    mesh_req_t r;
    r      = '0;
    r.cmd  = CMD_VERTEX;
    r.slot = IDX_W'(slot);
    r.x    = POS_W'(x);
    r.y    = POS_W'(y);
    r.z    = POS_W'(z);
    r.c0   = IDX_W'($urandom);   // ignored fields carry noise
    r.c1   = IDX_W'($urandom);
    r.c2   = IDX_W'($urandom);
    plan_x[slot] = POS_W'(x);
    plan_y[slot] = POS_W'(y);
    plan_z[slot] = POS_W'(z);
    mesh_requests = {mesh_requests, r};
  endtask

  task automatic queue_triangle(input int a, b, c);
    mesh_req_t r;
    r      = '0;
    r.cmd  = CMD_TRIANGLE;
    r.slot = IDX_W'($urandom);
    r.x    = POS_W'($urandom);
    r.y    = POS_W'($urandom);
    r.z    = POS_W'($urandom);
    r.c0   = IDX_W'(a);
    r.c1   = IDX_W'(b);
    r.c2   = IDX_W'(c);
    mesh_requests = {mesh_requests, r};
  endtask

  // registers change only with the block idle
  task automatic write_reg(input cfg_reg_t which, input logic [THR_W-1:0] value);
    int seen;
    seen = cfg_count;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_count == seen);
    cfg_valid <= 1'b0;
    if (which == REG_VERTICES_IN_USE)
      cur_viu = value[VIU_W-1:0];
  endtask

  // wait until every queued request went in and every status came back
  task automatic drain_block();
    do @(negedge clk);
    while (mesh_requests.size() != 0 || in_tvalid || awaited_status.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly triangles over the live range; vertex writes often followed by a
  // triangle through the fresh vertex, built to sit on a shared point or a line, or placed at random.
  task automatic random_phase(input int count);
    int span, hi_idx, n, r, a, b, c, s, w;
    int nx, ny, nz;
    span   = (cur_viu < VERTEX_DEPTH) ? cur_viu : VERTEX_DEPTH;
    // in-range corners stay inside the entries filled up front
    hi_idx = ((span > 0 && span < FILL_COUNT) ? span : FILL_COUNT) - 1;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      a = $urandom_range(0, hi_idx);
      b = $urandom_range(0, hi_idx);
      if (r < 22) begin
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, VERTEX_DEPTH - 1)
                                        : $urandom_range(0, hi_idx);
        nx = 2 * plan_x[b] - plan_x[a];
        ny = 2 * plan_y[b] - plan_y[a];
        nz = 2 * plan_z[b] - plan_z[a];
        case ($urandom_range(0, 3))
          0: queue_vertex(s, plan_x[a], plan_y[a], plan_z[a]);   // coincident point
          1: begin
            // extend edge a->b past b: collinear if it stays in range
            if (nx >= -32768 && nx <= 32767 && ny >= -32768 && ny <= 32767 &&
                nz >= -32768 && nz <= 32767)
              queue_vertex(s, nx, ny, nz);
            else
              queue_vertex(s, plan_x[b], plan_y[b], plan_z[b]);
          end
          default: begin
            w = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(2, 16);
            queue_vertex(s, rand_coord(w), rand_coord(w), rand_coord(w));
          end
        endcase
        if (span >= 3 && s <= hi_idx && s != a && s != b && a != b &&
            $urandom_range(0, 1) == 1)
          queue_triangle(a, b, s);
      end else begin
        c = $urandom_range(0, hi_idx);
        r = $urandom_range(0, 99);
        if (r < 10 && span < VERTEX_DEPTH) begin
          case ($urandom_range(0, 2))
            0:       a = $urandom_range(span, VERTEX_DEPTH - 1);
            1:       b = $urandom_range(span, VERTEX_DEPTH - 1);
            default: c = $urandom_range(span, VERTEX_DEPTH - 1);
          endcase
        end else if (r < 20) begin
          case ($urandom_range(0, 2))
            0:       b = a;
            1:       c = b;
            default: a = c;
          endcase
        end else if (span >= 3) begin
          while (b == a) b = $urandom_range(0, hi_idx);
          while (c == a || c == b) c = $urandom_range(0, hi_idx);
        end
        queue_triangle(a, b, c);
      end
    end
  endtask

  function automatic logic [THR_W-1:0] rand_limit();
    logic [THR_W-1:0] v;
    v = THR_W'({$urandom, $urandom});
    return v >> $urandom_range(0, THR_W - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int s;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_req = '0;
    in_fire = 1'b0;
    live_vertex_count = '0;
    live_area_limit = '0;
    cur_viu = 0;
    cfg_count = 0;
    cycle_count = 0;
    mismatch_count = 0;
    vertex_writes = 0;
    triangle_tests = 0;
    verdict_tally = '{default: 0};
    burst_left = 0;
    gap_left = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    rx_cycle = 0;
    rx_mode = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // fill the low entries first; random triangles that reach the area test only use these
    for (s = 0; s < FILL_COUNT; s++)
      queue_vertex(s, rand_coord($urandom_range(1, 16)), rand_coord($urandom_range(1, 16)),
                   rand_coord($urandom_range(1, 16)));

    // directed vertices: coordinate extremes, a unit right angle, a line
    queue_vertex(0, -32768, -32768, -32768);
    queue_vertex(1, 32767, 32767, -32768);
    queue_vertex(2, -32768, 32767, 32767);
    queue_vertex(VERTEX_DEPTH - 1, 32767, 32767, 32767);
    queue_vertex(3, 0, 0, 0);
    queue_vertex(4, 256, 0, 0);
    queue_vertex(5, 512, 0, 0);
    queue_vertex(6, 0, 256, 0);
    // registers still at reset: nothing is in range
    queue_triangle(0, 1, 2);
    queue_triangle(VERTEX_DEPTH - 1, 5, 6);
    drain_block();

    // threshold still zero from reset
    write_reg(REG_VERTICES_IN_USE, THR_W'(VERTEX_DEPTH));
    queue_triangle(0, 1, 2);
    queue_triangle(3, 4, 5);                 // collinear, zero area
    queue_triangle(3, 4, 6);                 // squared length exactly 2^32
    queue_triangle(3, 3, 5);                 // repeat beats area
    queue_triangle(4, 5, 5);
    queue_triangle(6, 4, 6);
    queue_triangle(0, 0, 0);
    queue_triangle(VERTEX_DEPTH - 1, 0, 1);
    drain_block();

    // index error beats repeat; threshold right at the unit triangle
    write_reg(REG_VERTICES_IN_USE, THR_W'(VERTEX_DEPTH - 1));
    write_reg(REG_AREA_THRESHOLD, 63'd1 << 32);
    queue_triangle(VERTEX_DEPTH - 1, VERTEX_DEPTH - 1, 0);
    queue_triangle(3, 4, 6);
    queue_triangle(0, 1, VERTEX_DEPTH - 1);
    drain_block();

    write_reg(REG_AREA_THRESHOLD, (63'd1 << 32) - 63'd1);
    queue_triangle(3, 4, 6);
    drain_block();

    // count beyond the store, threshold at max: only huge areas survive
    write_reg(REG_VERTICES_IN_USE, THR_W'((1 << VIU_W) - 1));
    write_reg(REG_AREA_THRESHOLD, {THR_W{1'b1}});
    queue_triangle(0, 1, 2);
    queue_triangle(3, 4, 6);
    queue_triangle(VERTEX_DEPTH - 1, 0, 1);
    drain_block();

    // random phases; each starts from an idle block
    write_reg(REG_VERTICES_IN_USE, THR_W'(700));
    write_reg(REG_AREA_THRESHOLD, 63'd1 << $urandom_range(20, 50));
    random_phase(90);
    hold_requests++;                         // back up the output while requests keep coming
    drain_block();

    write_reg(REG_VERTICES_IN_USE, THR_W'(3));
    write_reg(REG_AREA_THRESHOLD, '0);
    random_phase(50);
    drain_block();

    write_reg(REG_VERTICES_IN_USE, THR_W'((1 << VIU_W) - 1));
    write_reg(REG_AREA_THRESHOLD, {THR_W{1'b1}});
    random_phase(80);
    drain_block();

    write_reg(REG_VERTICES_IN_USE, THR_W'($urandom_range(0, VERTEX_DEPTH)));
    write_reg(REG_AREA_THRESHOLD, rand_limit());
    random_phase(80);
    drain_block();

    write_reg(REG_VERTICES_IN_USE, THR_W'(VERTEX_DEPTH));
    write_reg(REG_AREA_THRESHOLD, 63'd1 << $urandom_range(0, THR_W - 1));
    random_phase(120);
    hold_requests++;
    drain_block();

    $display("covered %0d vertex writes, %0d triangle tests, %0d register writes, %0d cycles",
             vertex_writes, triangle_tests, cfg_count, cycle_count);
    $display("statuses: kept %0d, repeated %0d, too small %0d, index error %0d; %0d mismatches",
             verdict_tally[VERDICT_KEPT], verdict_tally[VERDICT_REPEAT],
             verdict_tally[VERDICT_SMALL], verdict_tally[VERDICT_INDEX], mismatch_count);
    if (mismatch_count == 0)
      $display("degenerate_triangle_cull_top regression: pass");
    else
      $display("degenerate_triangle_cull_top regression: fail");
    $finish;
  end

endmodule
